// ===== hdl/stereo_comb_allpass_reverb_defines.svh =====
// assertion macros shared by the checker
`ifndef STEREO_COMB_ALLPASS_REVERB_DEFINES_SVH
`define STEREO_COMB_ALLPASS_REVERB_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet while arst_n is low
`define SCAR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define SCAR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== hdl/scar_pkg.sv =====
`default_nettype none
package scar_pkg;

	localparam int unsigned SAMPLE_BITS       = 16;
	localparam int unsigned DATA_BITS         = 24;
	localparam int unsigned Q16_BITS          = 17;
	localparam int unsigned Q16_ONE           = 65536;
	localparam int unsigned CFG_INDEX_BITS    = 3;
	localparam int unsigned SPREAD            = 23;
	localparam int unsigned REF_RATE          = 44100;
	localparam int unsigned COMB_SPAN         = 22232;
	localparam int unsigned AP_SPAN           = 3218;
	localparam int unsigned FB_BASE           = 45875;
	localparam int unsigned FB_SPAN           = 18350;
	localparam int unsigned MIX_GAIN          = 1638;
	localparam int unsigned FRAC              = 3;
	localparam int unsigned DEF_SAMPLE_RATE   = 44100;
	localparam int unsigned DEF_COMB_COUNT    = 8;
	localparam int unsigned DEF_ALLPASS_COUNT = 4;

	localparam int unsigned COMB_TUNE [8] = '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};
	localparam int unsigned AP_TUNE [4]   = '{556, 441, 341, 225};

	typedef logic signed [DATA_BITS-1:0] data_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] in_left;
		logic signed [SAMPLE_BITS-1:0] in_right;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_left;
		logic signed [SAMPLE_BITS-1:0] out_right;
	} out_item_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_ROOM_SIZE    = 3'd0,
		CFG_DAMPING      = 3'd1,
		CFG_DRY_WET      = 3'd2,
		CFG_STEREO_WIDTH = 3'd3,
		CFG_BYPASS       = 3'd4
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_SETUP,
		ST_C_RD, ST_C_MUL, ST_C_LAST, ST_C_WR,
		ST_AP_RD, ST_AP_WR,
		ST_O_L0, ST_O_L1, ST_O_L2, ST_O_R0, ST_O_R1, ST_O_R2, ST_O_FIN,
		ST_DONE
	} state_t;

	function automatic int unsigned scaled_len(input int unsigned rate, input int unsigned tune);
		int unsigned n;
		n = (rate * tune) / REF_RATE;
		return (n == 0) ? 1 : n;
	endfunction

	function automatic int unsigned comb_len(input int unsigned rate, input int unsigned count,
			input int unsigned k);
		int unsigned i;
		int unsigned extra;
		i = (k >= count) ? k - count : k;
		extra = (k >= count) ? SPREAD : 0;
		return scaled_len(rate, COMB_TUNE[i] + extra);
	endfunction

	function automatic int unsigned comb_base(input int unsigned rate, input int unsigned count,
			input int unsigned k);
		int unsigned b;
		b = 0;
		for (int unsigned j = 0; j < k; j++) b += comb_len(rate, count, j);
		return b;
	endfunction

	function automatic int unsigned ap_len(input int unsigned rate, input int unsigned count,
			input int unsigned k);
		int unsigned i;
		int unsigned extra;
		i = (k >= count) ? k - count : k;
		extra = (k >= count) ? SPREAD : 0;
		return scaled_len(rate, AP_TUNE[i] + extra);
	endfunction

	function automatic int unsigned ap_base(input int unsigned rate, input int unsigned count,
			input int unsigned k);
		int unsigned b;
		b = 0;
		for (int unsigned j = 0; j < k; j++) b += ap_len(rate, count, j);
		return b;
	endfunction

	function automatic data_t sat24(input logic signed [47:0] v);
		if (v > 48'sd8388607) return data_t'(24'sh7FFFFF);
		if (v < -48'sd8388608) return data_t'(24'sh800000);
		return data_t'(v);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] sat16(input logic signed [47:0] v);
		if (v > 48'sd32767) return 16'sh7FFF;
		if (v < -48'sd32768) return 16'sh8000;
		return v[SAMPLE_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/stereo_comb_allpass_reverb.sv =====
// channel   | direction | handshake            | payload
// in        | into      | in_valid / in_ready   | in_data (in_left, in_right)
// out       | out of    | out_valid / out_ready | out_data (out_left, out_right)
// cfg       | into      | cfg_wr_en             | cfg_index, cfg_data
//
// one sample pair at a time: the time from accept to result is set by the walk over
// every comb (read, two multiplies, write back) and allpass (read, write back); bypass
// skips the walk. in_ready rises again in the same cycle as the result is raised.
// after reset a clearing pass zeroes the delay memories, one entry a cycle, with in_ready
// low; cfg writes are taken throughout.
// a result waiting on out_ready holds the block before it goes idle again.
`default_nettype none
module stereo_comb_allpass_reverb #(
	parameter int unsigned SAMPLE_RATE   = scar_pkg::DEF_SAMPLE_RATE,
	parameter int unsigned COMB_COUNT    = scar_pkg::DEF_COMB_COUNT,
	parameter int unsigned ALLPASS_COUNT = scar_pkg::DEF_ALLPASS_COUNT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  scar_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output scar_pkg::out_item_t                  out_data,
	input  logic                                 cfg_wr_en,
	input  logic [scar_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [scar_pkg::Q16_BITS-1:0]        cfg_data
);
	import scar_pkg::*;

	localparam int unsigned COMB_DEPTH = (COMB_SPAN * SAMPLE_RATE) / REF_RATE + 2 * DEF_COMB_COUNT;
	localparam int unsigned AP_DEPTH   = (AP_SPAN * SAMPLE_RATE) / REF_RATE + 2 * DEF_ALLPASS_COUNT;
	localparam int unsigned CAW = $clog2(COMB_DEPTH);
	localparam int unsigned AAW = $clog2(AP_DEPTH);
	localparam int unsigned NC  = 2 * COMB_COUNT;
	localparam int unsigned NA  = 2 * ALLPASS_COUNT;
	localparam int unsigned KCW = $clog2(NC);
	localparam int unsigned KAW = $clog2(NA);
	localparam int unsigned PW  = $clog2(comb_len(SAMPLE_RATE, COMB_COUNT, NC - 1) + 1);
	localparam int unsigned SUMW = DATA_BITS + $clog2(COMB_COUNT) + 1;

	// constant tables of delay lengths and bases
	logic [CAW-1:0] cbase_tab [NC];
	logic [PW-1:0]  clen_tab  [NC];
	logic [AAW-1:0] abase_tab [NA];
	logic [PW-1:0]  alen_tab  [NA];

	for (genvar g = 0; g < NC; g++) begin : g_ctab
		assign cbase_tab[g] = CAW'(comb_base(SAMPLE_RATE, COMB_COUNT, g));
		assign clen_tab[g]  = PW'(comb_len(SAMPLE_RATE, COMB_COUNT, g));
	end
	for (genvar g = 0; g < NA; g++) begin : g_atab
		assign abase_tab[g] = AAW'(ap_base(SAMPLE_RATE, ALLPASS_COUNT, g));
		assign alen_tab[g]  = PW'(ap_len(SAMPLE_RATE, ALLPASS_COUNT, g));
	end

	// configuration
	logic [Q16_BITS-1:0] room_q, damping_q, dry_wet_q, width_q;
	logic                bypass_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_q    <= Q16_BITS'(32768);
			damping_q <= Q16_BITS'(32768);
			dry_wet_q <= Q16_BITS'(32768);
			width_q   <= Q16_BITS'(Q16_ONE);
			bypass_q  <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_ROOM_SIZE:    room_q    <= cfg_data;
				CFG_DAMPING:      damping_q <= cfg_data;
				CFG_DRY_WET:      dry_wet_q <= cfg_data;
				CFG_STEREO_WIDTH: width_q   <= cfg_data;
				CFG_BYPASS:       bypass_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// control state
	state_t          state_q, state_d;
	logic [KCW-1:0]  kc_q;
	logic [KAW-1:0]  ka_q;
	logic [CAW-1:0]  clr_q;
	logic [PW-1:0]   cpos_q [NC];
	logic [PW-1:0]   apos_q [NA];
	data_t           clp_q  [NC];
	logic            out_valid_q;
	out_item_t       out_q;

	// datapath registers
	in_item_t                   in_q;
	out_item_t                  res_q;
	logic [Q16_BITS-1:0]        damp_q, fb_q, dry_q, g2_q;
	logic [Q16_BITS:0]          g1_q;
	data_t                      mixed_q, o_q, x_q, wl_q, wr_q;
	logic signed [SUMW-1:0]     sum_q;
	logic signed [42:0]         p1_q;
	logic signed [41:0]         p2_q;
	logic signed [43:0]         acc_q;
	logic [CAW-1:0]             caddr_q;
	logic [AAW-1:0]             aaddr_q;

	// memories
	data_t          comb_mem [COMB_DEPTH];
	data_t          ap_mem   [AP_DEPTH];
	data_t          cm_rd_q, am_rd_q;
	logic           cm_we, am_we;
	logic [CAW-1:0] cm_raddr, cm_waddr;
	logic [AAW-1:0] am_raddr, am_waddr;
	data_t          cm_wdata, am_wdata;

	always_ff @(posedge clk) begin
		if (cm_we) comb_mem[cm_waddr] <= cm_wdata;
		cm_rd_q <= comb_mem[cm_raddr];
	end

	always_ff @(posedge clk) begin
		if (am_we) ap_mem[am_waddr] <= am_wdata;
		am_rd_q <= ap_mem[am_raddr];
	end

	// combinational helpers
	logic [Q16_BITS-1:0] room_c, damp_c, dw_c, wd_c;
	logic [32:0]         fbp;
	logic [34:0]         g1p, g2p;
	logic signed [SAMPLE_BITS:0] lr_sum;
	logic signed [47:0]  mix_p;
	logic [PW-1:0]       cpos_eff, apos_eff, cpos_inc, apos_inc;
	logic signed [24:0]  lp_diff;
	data_t               last_c, ap_x_c;
	logic                comb_ch_end, ap_ch_end, ap_all_end;
	logic signed [17:0]  damp_s, fb_s, dry_s;
	logic signed [18:0]  g1_s;
	logic signed [17:0]  g2_s;

	always_comb begin
		room_c = (room_q > Q16_BITS'(Q16_ONE)) ? Q16_BITS'(Q16_ONE) : room_q;
		damp_c = (damping_q > Q16_BITS'(Q16_ONE)) ? Q16_BITS'(Q16_ONE) : damping_q;
		dw_c   = (dry_wet_q > Q16_BITS'(Q16_ONE)) ? Q16_BITS'(Q16_ONE) : dry_wet_q;
		wd_c   = (width_q > Q16_BITS'(Q16_ONE)) ? Q16_BITS'(Q16_ONE) : width_q;
		fbp    = 33'(room_c) * 33'(FB_SPAN) + 33'(32768);
		g1p    = 35'(dw_c) * 35'(Q16_ONE + 32'(wd_c));
		g2p    = 35'(dw_c) * 35'(Q16_ONE - 32'(wd_c));
		lr_sum = 17'(in_q.in_left) + 17'(in_q.in_right);
		mix_p  = 48'(lr_sum) * 48'(MIX_GAIN << FRAC);

		cpos_eff = (cpos_q[kc_q] >= clen_tab[kc_q]) ? '0 : cpos_q[kc_q];
		cpos_inc = (cpos_eff + PW'(1) >= clen_tab[kc_q]) ? '0 : cpos_eff + PW'(1);
		apos_eff = (apos_q[ka_q] >= alen_tab[ka_q]) ? '0 : apos_q[ka_q];
		apos_inc = (apos_eff + PW'(1) >= alen_tab[ka_q]) ? '0 : apos_eff + PW'(1);

		lp_diff = 25'(clp_q[kc_q]) - 25'(cm_rd_q);
		last_c  = sat24(48'(o_q) + ((48'(p1_q) + 48'sd32768) >>> 16));
		ap_x_c  = sat24(48'(am_rd_q) - 48'(x_q));

		comb_ch_end = (kc_q == KCW'(COMB_COUNT - 1)) || (kc_q == KCW'(NC - 1));
		ap_ch_end   = (ka_q == KAW'(ALLPASS_COUNT - 1)) || (ka_q == KAW'(NA - 1));
		ap_all_end  = (ka_q == KAW'(NA - 1));

		damp_s = 18'(damp_q);
		fb_s   = 18'(fb_q);
		dry_s  = 18'(dry_q);
		g1_s   = 19'(g1_q);
		g2_s   = 18'(g2_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_q == CAW'(COMB_DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE:   if (in_valid) state_d = bypass_q ? ST_DONE : ST_SETUP;
			ST_SETUP:  state_d = ST_C_RD;
			ST_C_RD:   state_d = ST_C_MUL;
			ST_C_MUL:  state_d = ST_C_LAST;
			ST_C_LAST: state_d = ST_C_WR;
			ST_C_WR:   state_d = comb_ch_end ? ST_AP_RD : ST_C_RD;
			ST_AP_RD:  state_d = ST_AP_WR;
			ST_AP_WR: begin
				if (ap_all_end) state_d = ST_O_L0;
				else if (ap_ch_end) state_d = ST_C_RD;
				else state_d = ST_AP_RD;
			end
			ST_O_L0:   state_d = ST_O_L1;
			ST_O_L1:   state_d = ST_O_L2;
			ST_O_L2:   state_d = ST_O_R0;
			ST_O_R0:   state_d = ST_O_R1;
			ST_O_R1:   state_d = ST_O_R2;
			ST_O_R2:   state_d = ST_O_FIN;
			ST_O_FIN:  state_d = ST_DONE;
			ST_DONE:   if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready = 1'b0;
		cm_we    = 1'b0;
		am_we    = 1'b0;
		cm_raddr = cbase_tab[kc_q] + CAW'(cpos_eff);
		am_raddr = abase_tab[ka_q] + AAW'(apos_eff);
		cm_waddr = caddr_q;
		am_waddr = aaddr_q;
		cm_wdata = sat24(48'(mixed_q) + ((48'(p2_q) + 48'sd32768) >>> 16));
		am_wdata = sat24(48'(x_q) + ((48'(am_rd_q) + 48'sd1) >>> 1));
		case (state_q)
			ST_CLEAR: begin
				cm_we    = 1'b1;
				cm_waddr = clr_q;
				cm_wdata = '0;
				am_we    = (32'(clr_q) < AP_DEPTH);
				am_waddr = clr_q[AAW-1:0];
				am_wdata = '0;
			end
			ST_IDLE:  in_ready = 1'b1;
			ST_C_WR:  cm_we = 1'b1;
			ST_AP_WR: am_we = 1'b1;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			kc_q        <= '0;
			ka_q        <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NC; i++) begin
				cpos_q[i] <= '0;
				clp_q[i]  <= '0;
			end
			for (int i = 0; i < NA; i++) apos_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + CAW'(1);
			if (state_q == ST_C_LAST) clp_q[kc_q] <= last_c;
			if (state_q == ST_C_WR) begin
				cpos_q[kc_q] <= cpos_inc;
				kc_q <= (kc_q == KCW'(NC - 1)) ? '0 : kc_q + KCW'(1);
			end
			if (state_q == ST_AP_WR) begin
				apos_q[ka_q] <= apos_inc;
				ka_q <= ap_all_end ? '0 : ka_q + KAW'(1);
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				in_q            <= in_data;
				res_q.out_left  <= in_data.in_left;
				res_q.out_right <= in_data.in_right;
			end
			ST_SETUP: begin
				damp_q  <= damp_c;
				fb_q    <= Q16_BITS'(FB_BASE) + Q16_BITS'(fbp >> 16);
				dry_q   <= Q16_BITS'(Q16_ONE - 32'(dw_c));
				g1_q    <= (Q16_BITS + 1)'(g1p >> 16);
				g2_q    <= Q16_BITS'(g2p >> 16);
				mixed_q <= sat24((mix_p + 48'sd32768) >>> 16);
				sum_q   <= '0;
			end
			ST_C_RD:  caddr_q <= cm_raddr;
			ST_C_MUL: begin
				o_q   <= cm_rd_q;
				sum_q <= sum_q + SUMW'(cm_rd_q);
				p1_q  <= 43'(lp_diff) * 43'(damp_s);
			end
			ST_C_LAST: p2_q <= 42'(last_c) * 42'(fb_s);
			ST_C_WR: if (comb_ch_end) x_q <= sat24(48'(sum_q));
			ST_AP_RD: aaddr_q <= am_raddr;
			ST_AP_WR: begin
				x_q <= ap_x_c;
				if (ap_all_end) wr_q <= ap_x_c;
				else if (ap_ch_end) begin
					wl_q  <= ap_x_c;
					sum_q <= '0;
				end
			end
			ST_O_L0: acc_q <= (44'(in_q.in_left) * 44'(dry_s)) <<< FRAC;
			ST_O_L1: acc_q <= acc_q + 44'(wl_q) * 44'(g1_s);
			ST_O_L2: acc_q <= acc_q + 44'(wr_q) * 44'(g2_s);
			ST_O_R0: begin
				res_q.out_left <= sat16((48'(acc_q) + 48'sd262144) >>> (16 + FRAC));
				acc_q <= (44'(in_q.in_right) * 44'(dry_s)) <<< FRAC;
			end
			ST_O_R1: acc_q <= acc_q + 44'(wr_q) * 44'(g1_s);
			ST_O_R2: acc_q <= acc_q + 44'(wl_q) * 44'(g2_s);
			ST_O_FIN: res_q.out_right <= sat16((48'(acc_q) + 48'sd262144) >>> (16 + FRAC));
			ST_DONE: if (!out_valid_q || out_ready) out_q <= res_q;
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

// ===== hdl/scar_checker.sv =====
`default_nettype none
`include "stereo_comb_allpass_reverb_defines.svh"
module scar_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire scar_pkg::out_item_t out_data
);
	// a stalled result keeps its payload
	`SCAR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
	// one transaction in flight: no accept on the cycle after an accept
	`SCAR_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready, "input taken while busy")
	// ready only drops because a transaction was taken
	`SCAR_ASSERT_IMP(a_ready_drop, $fell(in_ready), $past(in_valid), "ready dropped without an accept")
	// a new result appears only while the input side is closed
	`SCAR_ASSERT_IMP(a_result_busy, $rose(out_valid), $past(!in_ready), "result raised while idle")
endmodule

bind stereo_comb_allpass_reverb scar_checker u_scar_checker (.*);
`default_nettype wire

// ===== verif/stereo_comb_allpass_reverb_tb.sv =====
`default_nettype none
module stereo_comb_allpass_reverb_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import scar_pkg::*;

	localparam int COMBS = 8;
	localparam int APS = 4;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = CFG_INDEX_BITS'(CFG_BYPASS + 1);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_wr_en = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [Q16_BITS-1:0] cfg_data = '0;

	stereo_comb_allpass_reverb u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// mirror of the block's registers and delay memories
	logic [Q16_BITS-1:0] room_r = 17'd32768, damp_r = 17'd32768, mix_r = 17'd32768;
	logic [Q16_BITS-1:0] width_r = 17'd65536;
	logic bypass_r = 1'b0;
	longint comb_mem [COMB_SPAN + 16];
	longint ap_mem [AP_SPAN + 8];
	int comb_len_r [2*COMBS], comb_at [2*COMBS], comb_pos [2*COMBS];
	longint comb_lp [2*COMBS];
	int ap_len_r [2*APS], ap_at [2*APS], ap_pos [2*APS];

	out_item_t expected_q [$];
	int mismatches = 0;
	int results_seen = 0;
	int items_sent = 0;
	int bypass_items = 0;
	bit idling = 1'b1;

	function automatic longint clip(longint v, int bits);
		longint hi;
		hi = (64'sd1 <<< (bits - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	// round half up, then drop s bits
	function automatic longint rnd(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	task automatic clear_model();
		int base;
		foreach (comb_mem[i]) comb_mem[i] = 0;
		foreach (ap_mem[i]) ap_mem[i] = 0;
		base = 0;
		for (int ch = 0; ch < 2; ch++)
			for (int i = 0; i < COMBS; i++) begin
				comb_len_r[ch*COMBS+i] = COMB_TUNE[i] + (ch ? SPREAD : 0);
				comb_at[ch*COMBS+i] = base;
				comb_pos[ch*COMBS+i] = 0;
				comb_lp[ch*COMBS+i] = 0;
				base += comb_len_r[ch*COMBS+i];
			end
		base = 0;
		for (int ch = 0; ch < 2; ch++)
			for (int i = 0; i < APS; i++) begin
				ap_len_r[ch*APS+i] = AP_TUNE[i] + (ch ? SPREAD : 0);
				ap_at[ch*APS+i] = base;
				ap_pos[ch*APS+i] = 0;
				base += ap_len_r[ch*APS+i];
			end
	endtask

	function automatic longint reverb_side(int ch, longint feed, longint fb, longint damp);
		longint sum, o, lp, x, b;
		int k, at;
		sum = 0;
		for (int c = 0; c < COMBS; c++) begin
			k = ch*COMBS + c;
			at = comb_at[k] + comb_pos[k];
			o = comb_mem[at];
			sum += o;
			lp = clip(o + rnd((comb_lp[k] - o) * damp, 16), 24);
			comb_lp[k] = lp;
			comb_mem[at] = clip(feed + rnd(lp * fb, 16), 24);
			comb_pos[k] = (comb_pos[k] + 1 >= comb_len_r[k]) ? 0 : comb_pos[k] + 1;
		end
		x = clip(sum, 24);
		for (int a = 0; a < APS; a++) begin
			k = ch*APS + a;
			at = ap_at[k] + ap_pos[k];
			b = ap_mem[at];
			ap_mem[at] = clip(x + rnd(b, 1), 24);
			x = clip(b - x, 24);
			ap_pos[k] = (ap_pos[k] + 1 >= ap_len_r[k]) ? 0 : ap_pos[k] + 1;
		end
		return x;
	endfunction

	function automatic out_item_t reverb_output(in_item_t x);
		out_item_t y;
		longint l, r, rm, dp, dw, wd, fb, dry, g1, g2, feed, wl, wr;
		l = longint'($signed(x.in_left));
		r = longint'($signed(x.in_right));
		if (bypass_r) begin
			y.out_left = x.in_left;
			y.out_right = x.in_right;
			return y;
		end
		rm = (room_r > Q16_ONE) ? Q16_ONE : room_r;
		dp = (damp_r > Q16_ONE) ? Q16_ONE : damp_r;
		dw = (mix_r > Q16_ONE) ? Q16_ONE : mix_r;
		wd = (width_r > Q16_ONE) ? Q16_ONE : width_r;
		fb = FB_BASE + ((rm * FB_SPAN + 32768) >>> 16);
		dry = Q16_ONE - dw;
		g1 = (dw * (Q16_ONE + wd)) >>> 16;
		g2 = (dw * (Q16_ONE - wd)) >>> 16;
		feed = clip(rnd((l + r) * 8 * MIX_GAIN, 16), 24);
		wl = reverb_side(0, feed, fb, dp);
		wr = reverb_side(1, feed, fb, dp);
		y.out_left = 16'(clip(rnd(l*dry*8 + wl*g1 + wr*g2, 19), 16));
		y.out_right = 16'(clip(rnd(r*dry*8 + wr*g1 + wl*g2, 19), 16));
		return y;
	endfunction

	// random out_ready stalls while idling; out_ready and out_valid both change only on nonblocking updates
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (arst_n && idling && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 9) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n;
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", out_data);
			end else begin
				want = expected_q.pop_front();
				if (out_data.out_left !== want.out_left || out_data.out_right !== want.out_right) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected L=%0d R=%0d, got L=%0d R=%0d",
							results_seen, want.out_left, want.out_right,
							out_data.out_left, out_data.out_right);
				end
			end
		end
	end

	task automatic send_pair(logic signed [15:0] l, logic signed [15:0] r);
		in_item_t x;
		x.in_left = l;
		x.in_right = r;
		if (idling && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= x;
		do @(posedge clk); while (!in_ready);
		expected_q.push_back(reverb_output(x));
		items_sent++;
		if (bypass_r) bypass_items++;
	endtask

	// wait until every expected transaction has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_regs(logic [16:0] rm, logic [16:0] dp, logic [16:0] dw,
			logic [16:0] wd, logic [16:0] byp);
		logic [16:0] vals [5];
		vals = '{rm, dp, dw, wd, byp};
		for (int i = 0; i < 5; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		// a write past the register list must change nothing
		cfg_index <= CFG_UNUSED;
		cfg_data <= 17'($urandom);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		room_r = rm;
		damp_r = dp;
		mix_r = dw;
		width_r = wd;
		bypass_r = byp[0];
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($urandom_range(0, 64)) - 16'd32;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_extremes();
		send_pair(16'sh0000, 16'sh0000);
		send_pair(16'sh7FFF, 16'sh7FFF);
		send_pair(-16'sh8000, -16'sh8000);
		send_pair(16'sh7FFF, -16'sh8000);
		send_pair(-16'sh8000, 16'sh7FFF);
		send_pair(16'sh0001, -16'sh0001);
		send_pair(16'sh5555, 16'shAAAA);
		repeat (3) send_pair(16'sh0000, 16'sh0000);
		drain();
	endtask

	task automatic test_bypass();
		set_regs(17'd32768, 17'd32768, 17'd32768, 17'd65536, 17'd1);
		send_pair(16'sh7FFF, -16'sh8000);
		send_pair(16'sh1234, 16'shEDCB);
		send_pair(-16'sh8000, 16'sh7FFF);
		drain();
	endtask

	// registers past one saturate; full-scale input at top feedback drives internal clipping
	task automatic test_saturation();
		set_regs(17'h1FFFF, 17'd0, 17'd65537, 17'd100000, 17'd0);
		repeat (6) send_pair(16'sh7FFF, 16'sh7FFF);
		repeat (4) send_pair(-16'sh8000, -16'sh8000);
		drain();
		set_regs(17'd65536, 17'd65536, 17'd0, 17'd0, 17'd0);
		send_pair(16'sh7FFF, -16'sh8000);
		drain();
	endtask

	task automatic test_random();
		logic [16:0] corners [6];
		corners = '{17'd0, 17'd65536, 17'd32768, 17'h1FFFF, 17'd1, 17'd65535};
		for (int ph = 0; ph < 10; ph++) begin
			idling = (ph < 8);
			if (ph == 0)
				set_regs(17'd0, 17'd0, 17'd0, 17'd0, 17'd0);
			else if (ph == 1)
				set_regs(17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd0);
			else if (ph == 5)
				set_regs(17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom), 17'd1);
			else
				set_regs(corners[$urandom_range(0, 5)] ^ 17'($urandom_range(0, 1) ? 0 : $urandom),
					17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
					corners[$urandom_range(0, 5)], {16'($urandom), 1'b0});
			repeat (ph == 5 ? 40 : 185) send_pair(pick_sample(), pick_sample());
			drain();
		end
	endtask

	initial begin
		clear_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_extremes();
		test_bypass();
		test_saturation();
		test_random();
		$display("%0d sample pairs sent (%0d in bypass), %0d results checked", items_sent,
			bypass_items, results_seen);
		$display("settings covered register extremes, saturated registers and full-scale input");
		if (mismatches == 0 && expected_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#60ms;
		$display("timeout with %0d results outstanding", expected_q.size());
		$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire

// ===== stereo_comb_allpass_reverb.f =====
+incdir+hdl
hdl/scar_pkg.sv
hdl/stereo_comb_allpass_reverb.sv
hdl/scar_checker.sv
verif/stereo_comb_allpass_reverb_tb.sv
